FILE: hw/rtl/hrlp_pkg.sv
// shared types and constants for the http request line parser
// no dependencies; used by hrlp_tokenizer and http_request_line_parser

package hrlp_pkg;

	// character codes the parser looks for
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// byte position width and the value it saturates at
	localparam int unsigned IDX_W = 16;
	localparam logic [IDX_W-1:0] INDEX_CEIL = 16'hFFFF;

	// parse phase, one-hot
	typedef enum logic [10:0] {
		PH_METHOD_BEGIN  = 11'b000_0000_0001,
		PH_METHOD        = 11'b000_0000_0010,
		PH_URI_BEGIN     = 11'b000_0000_0100,
		PH_URI           = 11'b000_0000_1000,
		PH_VERSION_BEGIN = 11'b000_0001_0000,
		PH_VERSION       = 11'b000_0010_0000,
		PH_AFTER_CR      = 11'b000_0100_0000,
		PH_LINE_START    = 11'b000_1000_0000,
		PH_IN_LINE       = 11'b001_0000_0000,
		PH_BLANK_CR      = 11'b010_0000_0000,
		PH_DONE          = 11'b100_0000_0000
	} phase_t;

	// token marker codes
	typedef enum logic [2:0] {
		MK_NONE          = 3'd0,
		MK_METHOD_START  = 3'd1,
		MK_METHOD_END    = 3'd2,
		MK_URI_START     = 3'd3,
		MK_URI_END       = 3'd4,
		MK_VERSION_START = 3'd5,
		MK_VERSION_END   = 3'd6,
		MK_HEADERS_END   = 3'd7
	} marker_t;

	// result of one request byte
	typedef struct packed {
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       out_byte;
		marker_t          marker;
		logic             complete;
	} result_t;

endpackage

FILE: hw/rtl/hrlp_tokenizer.sv
// parse phase and byte position registers with the per-byte next-state logic
// depends on hrlp_pkg

module hrlp_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic [7:0]         data_byte,
	input  logic               restart,
	output hrlp_pkg::result_t  result
);

	hrlp_pkg::phase_t                 phase_q;
	hrlp_pkg::phase_t                 cur_phase;
	hrlp_pkg::phase_t                 nxt_phase;
	logic [hrlp_pkg::IDX_W-1:0]       pos_q;
	logic [hrlp_pkg::IDX_W-1:0]       cur_pos;
	logic [hrlp_pkg::IDX_W-1:0]       nxt_pos;
	logic [7:0]                       ob;
	hrlp_pkg::marker_t                mk;
	logic                             done;
	logic                             is_sp;
	logic                             is_cr;
	logic                             is_lf;

	// restart makes this byte the first of a new request
	assign cur_phase = restart ? hrlp_pkg::PH_METHOD_BEGIN : phase_q;
	assign cur_pos   = restart ? '0 : pos_q;
	assign nxt_pos   = (cur_pos != hrlp_pkg::INDEX_CEIL) ? cur_pos + 1'b1 : cur_pos;

	assign is_sp = (data_byte == hrlp_pkg::CH_SP);
	assign is_cr = (data_byte == hrlp_pkg::CH_CR);
	assign is_lf = (data_byte == hrlp_pkg::CH_LF);

	// phase transitions, markers and delimiter zeroing
	always_comb begin
		nxt_phase = cur_phase;
		ob        = data_byte;
		mk        = hrlp_pkg::MK_NONE;
		done      = 1'b0;
		unique case (cur_phase)
			hrlp_pkg::PH_METHOD_BEGIN: begin
				mk        = hrlp_pkg::MK_METHOD_START;
				nxt_phase = hrlp_pkg::PH_METHOD;
			end
			hrlp_pkg::PH_METHOD: begin
				if (is_sp) begin
					ob        = '0;
					mk        = hrlp_pkg::MK_METHOD_END;
					nxt_phase = hrlp_pkg::PH_URI_BEGIN;
				end
			end
			hrlp_pkg::PH_URI_BEGIN: begin
				mk        = hrlp_pkg::MK_URI_START;
				nxt_phase = hrlp_pkg::PH_URI;
			end
			hrlp_pkg::PH_URI: begin
				if (is_sp) begin
					ob        = '0;
					mk        = hrlp_pkg::MK_URI_END;
					nxt_phase = hrlp_pkg::PH_VERSION_BEGIN;
				end
			end
			hrlp_pkg::PH_VERSION_BEGIN: begin
				mk        = hrlp_pkg::MK_VERSION_START;
				nxt_phase = hrlp_pkg::PH_VERSION;
			end
			hrlp_pkg::PH_VERSION: begin
				if (is_cr) begin
					ob        = '0;
					mk        = hrlp_pkg::MK_VERSION_END;
					nxt_phase = hrlp_pkg::PH_AFTER_CR;
				end
			end
			hrlp_pkg::PH_AFTER_CR: begin
				if (is_lf)
					nxt_phase = hrlp_pkg::PH_LINE_START;
				else if (is_cr)
					nxt_phase = hrlp_pkg::PH_AFTER_CR;
				else
					nxt_phase = hrlp_pkg::PH_IN_LINE;
			end
			hrlp_pkg::PH_LINE_START: begin
				nxt_phase = is_cr ? hrlp_pkg::PH_BLANK_CR : hrlp_pkg::PH_IN_LINE;
			end
			hrlp_pkg::PH_IN_LINE: begin
				if (is_cr)
					nxt_phase = hrlp_pkg::PH_AFTER_CR;
			end
			hrlp_pkg::PH_BLANK_CR: begin
				if (is_lf) begin
					mk        = hrlp_pkg::MK_HEADERS_END;
					done      = 1'b1;
					nxt_phase = hrlp_pkg::PH_DONE;
				end else if (is_cr) begin
					nxt_phase = hrlp_pkg::PH_AFTER_CR;
				end else begin
					nxt_phase = hrlp_pkg::PH_IN_LINE;
				end
			end
			default: begin
				// headers closed: pass bytes through
				done      = 1'b1;
				nxt_phase = hrlp_pkg::PH_DONE;
			end
		endcase
	end

	assign result.byte_index = cur_pos;
	assign result.out_byte   = ob;
	assign result.marker     = mk;
	assign result.complete   = done;

	// state update once per request byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrlp_pkg::PH_METHOD_BEGIN;
			pos_q   <= '0;
		end else if (step_en) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
		end
	end

	// a restarted byte sits at index zero, so the next one is at one
	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && restart |=> pos_q == hrlp_pkg::IDX_W'(1))
		else $error("position not one after restart");

	// once done, the phase stays done until a restart
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !restart && phase_q == hrlp_pkg::PH_DONE |=>
		phase_q == hrlp_pkg::PH_DONE)
		else $error("parser left done without restart");

	// the position never wraps back to zero without a restart
	a_pos_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !restart && pos_q != '0 |=> pos_q != '0)
		else $error("byte position wrapped");

endmodule

FILE: hw/rtl/http_request_line_parser.sv
// top level of the http request line parser: input register, tokenizer, result register
// depends on hrlp_pkg and hrlp_tokenizer

// Parses an HTTP request one byte per request on the input channel and
// returns one result per byte: its saturating index, the byte (zeroed when
// it ends the method, URI or version), a token marker and the complete
// flag set from the final LF of the blank line onward. One byte is taken
// every clock cycle when the output side is not stalled. An accepted byte
// lands in the input register, and its result is loaded into the result
// register when that register is empty or its result is being taken. The
// parse phase and byte position are updated as that result is loaded, by a
// single compare-and-select step. Raise restart with the first byte of a
// new request.

module http_request_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] byte_index,
	output logic [7:0]  out_byte,
	output logic [2:0]  marker,
	output logic        complete
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              restart_s1;
	logic              out_valid_q;
	hrlp_pkg::result_t result_q;
	hrlp_pkg::result_t step_res;
	logic              advance;
	logic              step_en;

	// result register can load when empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	hrlp_tokenizer u_tokenizer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.result    (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= step_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_index = result_q.byte_index;
	assign out_byte   = result_q.out_byte;
	assign marker     = result_q.marker;
	assign complete   = result_q.complete;

	// input side only backs up when both stages hold a request
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");

	// token-ending delimiters go out as zero
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (marker == hrlp_pkg::MK_METHOD_END || marker == hrlp_pkg::MK_URI_END
		|| marker == hrlp_pkg::MK_VERSION_END) |-> out_byte == 8'h00)
		else $error("token end byte not zeroed");

	// headers end marker comes with complete
	a_hdr_end_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && marker == hrlp_pkg::MK_HEADERS_END |-> complete)
		else $error("headers end without complete");

endmodule
